FILE: hdl/bqf_pkg.sv
package bqf_pkg;

  // fixed formats
  localparam int GAIN_BITS = 32;
  localparam int GAIN_FRAC = 24;
  localparam int NUM_COEFS = 5;

  // register indexes on the configuration port
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_A0  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_A1  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_A2  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_B1  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_B2  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_GAIN = 3'd5;

  // multiplier sample operand
  typedef enum logic [2:0] {
    ASEL_X,
    ASEL_X1,
    ASEL_X2,
    ASEL_Y1,
    ASEL_Y2
  } a_sel_e;

  // multiplier coefficient operand
  typedef enum logic [2:0] {
    BSEL_A0,
    BSEL_A1,
    BSEL_A2,
    BSEL_B1,
    BSEL_B2,
    BSEL_GAIN
  } b_sel_e;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD,
    ACC_SUB
  } acc_op_e;

  // step hold conditions
  typedef enum logic [1:0] {
    COND_NONE,
    COND_WAIT_IN,
    COND_WAIT_OUT
  } cond_e;

  // one microcode word
  typedef struct packed {
    a_sel_e  a_sel;
    b_sel_e  b_sel;
    logic    mul_en;
    acc_op_e acc_op;
    logic    y_wr;
    logic    out_wr;
    cond_e   cond;
    logic    last;
  } ctrl_t;

  localparam int STEP_W = 4;
  typedef logic [STEP_W-1:0] step_t;

  localparam step_t STEP_IDLE   = 4'd0;
  localparam step_t STEP_M_A0   = 4'd1;
  localparam step_t STEP_M_A1   = 4'd2;
  localparam step_t STEP_M_A2   = 4'd3;
  localparam step_t STEP_M_B1   = 4'd4;
  localparam step_t STEP_M_B2   = 4'd5;
  localparam step_t STEP_ACC_B2 = 4'd6;
  localparam step_t STEP_Y      = 4'd7;
  localparam step_t STEP_M_GAIN = 4'd8;
  localparam step_t STEP_OUT    = 4'd9;

  function automatic ctrl_t mk_word(a_sel_e a, b_sel_e b, logic m, acc_op_e op,
                                    logic yw, logic ow, cond_e c, logic l);
    ctrl_t w;
    w.a_sel  = a;
    w.b_sel  = b;
    w.mul_en = m;
    w.acc_op = op;
    w.y_wr   = yw;
    w.out_wr = ow;
    w.cond   = c;
    w.last   = l;
    return w;
  endfunction

  // microcode rom: each product is accumulated one step after it is formed
  function automatic ctrl_t ucode_rom(step_t s);
    ctrl_t w;
    unique case (s)
      STEP_IDLE:   w = mk_word(ASEL_X,  BSEL_A0,   1'b0, ACC_HOLD, 1'b0, 1'b0,
                               COND_WAIT_IN, 1'b0);
      STEP_M_A0:   w = mk_word(ASEL_X,  BSEL_A0,   1'b1, ACC_HOLD, 1'b0, 1'b0,
                               COND_NONE, 1'b0);
      STEP_M_A1:   w = mk_word(ASEL_X1, BSEL_A1,   1'b1, ACC_LOAD, 1'b0, 1'b0,
                               COND_NONE, 1'b0);
      STEP_M_A2:   w = mk_word(ASEL_X2, BSEL_A2,   1'b1, ACC_ADD,  1'b0, 1'b0,
                               COND_NONE, 1'b0);
      STEP_M_B1:   w = mk_word(ASEL_Y1, BSEL_B1,   1'b1, ACC_ADD,  1'b0, 1'b0,
                               COND_NONE, 1'b0);
      STEP_M_B2:   w = mk_word(ASEL_Y2, BSEL_B2,   1'b1, ACC_SUB,  1'b0, 1'b0,
                               COND_NONE, 1'b0);
      STEP_ACC_B2: w = mk_word(ASEL_X,  BSEL_A0,   1'b0, ACC_SUB,  1'b0, 1'b0,
                               COND_NONE, 1'b0);
      STEP_Y:      w = mk_word(ASEL_X,  BSEL_A0,   1'b0, ACC_HOLD, 1'b1, 1'b0,
                               COND_NONE, 1'b0);
      STEP_M_GAIN: w = mk_word(ASEL_Y1, BSEL_GAIN, 1'b1, ACC_HOLD, 1'b0, 1'b0,
                               COND_NONE, 1'b0);
      STEP_OUT:    w = mk_word(ASEL_X,  BSEL_A0,   1'b0, ACC_HOLD, 1'b0, 1'b1,
                               COND_WAIT_OUT, 1'b1);
      default:     w = mk_word(ASEL_X,  BSEL_A0,   1'b0, ACC_HOLD, 1'b0, 1'b0,
                               COND_NONE, 1'b1);
    endcase
    return w;
  endfunction

endpackage

FILE: hdl/bqf_seq.sv
module bqf_seq (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          out_free_i,
  output bqf_pkg::ctrl_t ctrl_o
);
  import bqf_pkg::*;

  step_t step_q, step_d;
  ctrl_t ctrl;
  logic  hold;

  // control word for the current step
  assign ctrl   = ucode_rom(step_q);
  assign ctrl_o = ctrl;

  // conditional hold, otherwise advance or jump back to the start
  always_comb begin
    unique case (ctrl.cond)
      COND_WAIT_IN:  hold = !in_valid_i;
      COND_WAIT_OUT: hold = !out_free_i;
      default:       hold = 1'b0;
    endcase
    if (hold) begin
      step_d = step_q;
    end else if (ctrl.last) begin
      step_d = STEP_IDLE;
    end else begin
      step_d = step_q + step_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

FILE: hdl/bqf_datapath.sv
module bqf_datapath #(
  parameter int SAMPLE_BITS = 24,
  parameter int COEF_BITS   = 32
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  bqf_pkg::ctrl_t                                ctrl_i,
  input  logic                                          in_fire_i,
  input  logic signed [SAMPLE_BITS-1:0]                 in_sample_i,
  input  logic [bqf_pkg::NUM_COEFS-1:0][COEF_BITS-1:0]  coef_i,
  input  logic signed [bqf_pkg::GAIN_BITS-1:0]          gain_i,
  output logic signed [SAMPLE_BITS-1:0]                 result_o
);
  import bqf_pkg::*;

  localparam int MB_W  = (COEF_BITS > GAIN_BITS) ? COEF_BITS : GAIN_BITS;
  localparam int P_W   = SAMPLE_BITS + MB_W;
  localparam int ACC_W = (SAMPLE_BITS + COEF_BITS + 4 < 64) ? SAMPLE_BITS + COEF_BITS + 4 : 64;
  localparam int GP_W  = (SAMPLE_BITS + GAIN_BITS + 1 < 64) ? SAMPLE_BITS + GAIN_BITS + 1 : 64;
  localparam int CF    = COEF_BITS - 3;

  localparam logic signed [ACC_W-1:0] ACC_HALF = ACC_W'(1) << (CF - 1);
  localparam logic signed [ACC_W-1:0] ACC_MAX  =
    {{(ACC_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN  =
    {{(ACC_W-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic signed [GP_W-1:0]  GP_HALF  = GP_W'(1) << (GAIN_FRAC - 1);
  localparam logic signed [GP_W-1:0]  GP_MAX   =
    {{(GP_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [GP_W-1:0]  GP_MIN   =
    {{(GP_W-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic signed [SAMPLE_BITS-1:0] x_q, x1_q, x2_q, y1_q, y2_q;
  logic signed [SAMPLE_BITS-1:0] mul_a, y_d;
  logic signed [MB_W-1:0]        mul_b;
  logic signed [P_W-1:0]         prod_q;
  logic signed [ACC_W-1:0]       acc_q, acc_d, acc_rnd, acc_shf;
  logic signed [GP_W-1:0]        g_rnd, g_shf;

  // operand selection
  always_comb begin
    unique case (ctrl_i.a_sel)
      ASEL_X1: mul_a = x1_q;
      ASEL_X2: mul_a = x2_q;
      ASEL_Y1: mul_a = y1_q;
      ASEL_Y2: mul_a = y2_q;
      default: mul_a = x_q;
    endcase
    unique case (ctrl_i.b_sel)
      BSEL_A1:   mul_b = MB_W'(signed'(coef_i[1]));
      BSEL_A2:   mul_b = MB_W'(signed'(coef_i[2]));
      BSEL_B1:   mul_b = MB_W'(signed'(coef_i[3]));
      BSEL_B2:   mul_b = MB_W'(signed'(coef_i[4]));
      BSEL_GAIN: mul_b = MB_W'(gain_i);
      default:   mul_b = MB_W'(signed'(coef_i[0]));
    endcase
  end

  // accumulator update from the registered product
  always_comb begin
    case (ctrl_i.acc_op)
      ACC_LOAD: acc_d = ACC_W'(prod_q);
      ACC_ADD:  acc_d = acc_q + ACC_W'(prod_q);
      ACC_SUB:  acc_d = acc_q - ACC_W'(prod_q);
      default:  acc_d = acc_q;
    endcase
  end

  // filtered value: round half up, then clamp to the sample range
  always_comb begin
    acc_rnd = acc_q + ACC_HALF;
    acc_shf = acc_rnd >>> CF;
    if (acc_shf > ACC_MAX) begin
      y_d = S_MAX;
    end else if (acc_shf < ACC_MIN) begin
      y_d = S_MIN;
    end else begin
      y_d = acc_shf[SAMPLE_BITS-1:0];
    end
  end

  // gain result from the product register
  always_comb begin
    g_rnd = GP_W'(prod_q) + GP_HALF;
    g_shf = g_rnd >>> GAIN_FRAC;
    if (g_shf > GP_MAX) begin
      result_o = S_MAX;
    end else if (g_shf < GP_MIN) begin
      result_o = S_MIN;
    end else begin
      result_o = g_shf[SAMPLE_BITS-1:0];
    end
  end

  // input sample, shared multiplier, product and accumulator registers
  always_ff @(posedge clk_i) begin
    if (in_fire_i) begin
      x_q <= in_sample_i;
    end
    if (ctrl_i.mul_en) begin
      prod_q <= P_W'(mul_a) * P_W'(mul_b);
    end
    acc_q <= acc_d;
  end

  // filter history
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x1_q <= '0;
      x2_q <= '0;
      y1_q <= '0;
      y2_q <= '0;
    end else if (ctrl_i.y_wr) begin
      x2_q <= x1_q;
      x1_q <= x_q;
      y2_q <= y1_q;
      y1_q <= y_d;
    end
  end

endmodule

FILE: hdl/biquad_iir_filter_unit.sv
// Second-order IIR filter (direct form I) for one channel of Q1.23 audio. Each
// sample runs through a ten-step microcode program on a single shared multiplier:
// five coefficient products accumulated at full width, rounding and saturation of
// the filtered value, then the gain product; a new sample enters only at the idle
// step. The finished sample waits in an output register, so the next input is
// accepted while it is still unread; only a stalled consumer holds the last step.
// The coefficients (Q3.29) and gain (Q8.24) are written through the configuration
// port; the user must write them only while the filter is idle; the block does
// not enforce it. Reset gives unity gain and a pass-through filter.
module biquad_iir_filter_unit #(
  parameter int SAMPLE_BITS = 24,
  parameter int COEF_BITS   = 32
) (
  input  logic                                             clk_i,
  input  logic                                             rst_ni,
  // s_axis_tdata: in_sample
  input  logic                                             s_axis_tvalid,
  output logic                                             s_axis_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]                 s_axis_tdata,
  // m_axis_tdata: out_sample
  output logic                                             m_axis_tvalid,
  input  logic                                             m_axis_tready,
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]                 m_axis_tdata,
  input  logic                                             cfg_we_i,
  input  logic [bqf_pkg::CFG_IDX_W-1:0]                    cfg_idx_i,
  input  logic [((COEF_BITS > 32) ? COEF_BITS : 32)-1:0]   cfg_data_i
);
  import bqf_pkg::*;

  localparam int TD_W = ((SAMPLE_BITS + 7) / 8) * 8;

  ctrl_t                                ctrl;
  logic                                 in_fire, out_free;
  logic [NUM_COEFS-1:0][COEF_BITS-1:0]  coef_q;
  logic signed [GAIN_BITS-1:0]          gain_q;
  logic signed [SAMPLE_BITS-1:0]        result;
  logic                                 out_valid_q;
  logic [SAMPLE_BITS-1:0]               out_data_q;

  // handshakes
  assign s_axis_tready = (ctrl.cond == COND_WAIT_IN);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = TD_W'(out_data_q);

  bqf_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .out_free_i (out_free),
    .ctrl_o     (ctrl)
  );

  bqf_datapath #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COEF_BITS   (COEF_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .in_fire_i   (in_fire),
    .in_sample_i (s_axis_tdata[SAMPLE_BITS-1:0]),
    .coef_i      (coef_q),
    .gain_i      (gain_q),
    .result_o    (result)
  );

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= {{((NUM_COEFS - 1) * COEF_BITS){1'b0}}, COEF_BITS'(1) << (COEF_BITS - 3)};
      gain_q <= GAIN_BITS'(1) << GAIN_FRAC;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_COEF_A0:  coef_q[0] <= cfg_data_i[COEF_BITS-1:0];
        REG_COEF_A1:  coef_q[1] <= cfg_data_i[COEF_BITS-1:0];
        REG_COEF_A2:  coef_q[2] <= cfg_data_i[COEF_BITS-1:0];
        REG_COEF_B1:  coef_q[3] <= cfg_data_i[COEF_BITS-1:0];
        REG_COEF_B2:  coef_q[4] <= cfg_data_i[COEF_BITS-1:0];
        REG_OUT_GAIN: gain_q    <= cfg_data_i[GAIN_BITS-1:0];
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.out_wr && out_free) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.out_wr && out_free) begin
      out_data_q <= result;
    end
  end

endmodule

FILE: bench/biquad_iir_filter_unit_test.sv
`timescale 1ns / 100ps

module biquad_iir_filter_unit_test;
  import bqf_pkg::*;

  localparam int SW          = 24;
  localparam int CW          = 32;
  localparam int TDATA_W     = ((SW + 7) / 8) * 8;
  localparam int CFG_W       = (CW > 32) ? CW : 32;
  localparam int COEF_FRAC   = CW - 3;
  localparam int NUM_REGS    = int'(REG_OUT_GAIN) + 1;
  localparam int PHASES      = 14;
  localparam int PHASE_ITEMS = 125;
  localparam int LONG_STALL  = 400;
  localparam int QUIET_LIMIT = 4000;
  localparam int REPORT_MAX  = 40;

  localparam logic [SW-1:0] S_MAX = {1'b0, {(SW - 1){1'b1}}};
  localparam logic [SW-1:0] S_MIN = {1'b1, {(SW - 1){1'b0}}};
  localparam longint L_MAX = (longint'(1) <<< (SW - 1)) - 1;
  localparam longint L_MIN = -(longint'(1) <<< (SW - 1));

  // clock, reset and block inputs, all known from time zero
  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [TDATA_W-1:0] s_axis_tdata  = '0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [TDATA_W-1:0] m_axis_tdata;
  logic               cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i   = '0;
  logic [CFG_W-1:0]   cfg_data_i    = '0;

  // filter copy: register file and delay line
  longint coef_reg [NUM_REGS];
  longint x_d1, x_d2, y_d1, y_d2;

  logic [SW-1:0] sample_queue [$];
  logic [SW-1:0] out_expected [$];

  bit in_taken;
  bit out_taken;
  int errors;
  int quiet_cycles;
  int tx_gap, tx_burst;
  int rx_hold, rx_burst;
  int long_hold_req, long_hold_seen;

  biquad_iir_filter_unit #(
    .SAMPLE_BITS(SW),
    .COEF_BITS  (CW)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // shift right with round half up, floor of the biased value
  function automatic longint round_shift(input longint v, input int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clamp_sample(input longint v);
    if (v > L_MAX) return L_MAX;
    if (v < L_MIN) return L_MIN;
    return v;
  endfunction

  // one sample through the direct form I section, then the output gain
  function automatic logic [SW-1:0] filter_step(input logic [SW-1:0] raw);
    longint x, acc, y, res;
    x = longint'($signed(raw));
    acc = coef_reg[REG_COEF_A0] * x + coef_reg[REG_COEF_A1] * x_d1
        + coef_reg[REG_COEF_A2] * x_d2 - coef_reg[REG_COEF_B1] * y_d1
        - coef_reg[REG_COEF_B2] * y_d2;
    y = clamp_sample(round_shift(acc, COEF_FRAC));
    x_d2 = x_d1;
    x_d1 = x;
    y_d2 = y_d1;
    y_d1 = y;
    res = clamp_sample(round_shift(y * coef_reg[REG_OUT_GAIN], GAIN_FRAC));
    return res[SW-1:0];
  endfunction

  // gap length: mostly short, a few long, with stretches of none
  function automatic int pick_gap(inout int burst);
    int r;
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(99) < 2) begin
      burst = $urandom_range(100, 30);
      return 0;
    end
    r = $urandom_range(99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(15, 4);
    return $urandom_range(80, 30);
  endfunction

  function automatic logic [SW-1:0] random_sample();
    case ($urandom_range(9))
      0:       return $urandom_range(1) ? S_MAX : S_MIN;
      1, 2, 3: return SW'($urandom());
      4, 5, 6: return SW'($urandom_range(8191) - 4096);
      default: return SW'($urandom_range(1 << 21) - (1 << 20));
    endcase
  endfunction

  // register write, mirrored into the filter copy
  task automatic write_reg(input int idx, input logic [31:0] value);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx[CFG_IDX_W-1:0];
    cfg_data_i <= CFG_W'(value);
    if (idx < NUM_REGS) coef_reg[idx] = longint'($signed(value));
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // every queued sample sent and every result received, checked once the
  // falling-edge updates of the driver have settled
  task automatic wait_idle();
    while (sample_queue.size() != 0 || s_axis_tvalid || out_expected.size() != 0) begin
      @(negedge clk_i);
      #1;
    end
  endtask

  task automatic random_config(input int style);
    logic [31:0] value;
    for (int r = 0; r < NUM_REGS; r++) begin
      case (style)
        // plausible filters near unity gain
        0: begin
          if (r == REG_OUT_GAIN) value = $urandom_range(32'h0200_0000);
          else if (r == REG_COEF_B1) value = $urandom_range(32'h8000_0000) - 32'h4000_0000;
          else if (r == REG_COEF_B2) value = $urandom_range(32'h3c00_0000) - 32'h1e00_0000;
          else value = $urandom_range(32'h4000_0000) - 32'h2000_0000;
        end
        1: value = $urandom();
        // extremes mixed with zero and small values
        default: begin
          case ($urandom_range(4))
            0: value = 32'h7fff_ffff;
            1: value = 32'h8000_0000;
            2: value = '0;
            3: value = $urandom();
            default: value = $urandom_range(511) - 256;
          endcase
        end
      endcase
      write_reg(r, value);
    end
  endtask

  // input driver, changes on the falling edge
  always @(negedge clk_i) begin
    logic          nxt_valid;
    logic [SW-1:0] nxt_data;
    nxt_valid = s_axis_tvalid;
    nxt_data  = s_axis_tdata[SW-1:0];
    if (!s_axis_tvalid || in_taken) begin
      nxt_valid = 1'b0;
      if (tx_gap > 0) begin
        tx_gap--;
      end else if (sample_queue.size() != 0) begin
        nxt_valid = 1'b1;
        nxt_data  = sample_queue.pop_front();
        tx_gap    = pick_gap(tx_burst);
      end
    end
    s_axis_tvalid <= nxt_valid;
    s_axis_tdata  <= TDATA_W'(nxt_data);
  end

  // result receiver with random stalls and an occasional long hold-off
  always @(negedge clk_i) begin
    if (long_hold_seen != long_hold_req) begin
      long_hold_seen = long_hold_req;
      rx_hold = LONG_STALL;
    end
    if (rx_hold > 0) begin
      rx_hold--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if ($urandom_range(3) == 0) rx_hold = pick_gap(rx_burst);
    end
  end

  // transaction monitor, scoreboard and watchdog
  always @(posedge clk_i) begin
    logic [SW-1:0] want;
    if (rst_ni) begin
      in_taken  = s_axis_tvalid && s_axis_tready;
      out_taken = m_axis_tvalid && m_axis_tready;
      if (out_taken) begin
        if (out_expected.size() == 0) begin
          errors++;
          if (errors <= REPORT_MAX)
            $display("%0t: unexpected result, expected none, actual %h", $time,
                     m_axis_tdata[SW-1:0]);
        end else begin
          want = out_expected.pop_front();
          if (m_axis_tdata[SW-1:0] !== want) begin
            errors++;
            if (errors <= REPORT_MAX)
              $display("%0t: out_sample mismatch, expected %h, actual %h", $time, want,
                       m_axis_tdata[SW-1:0]);
          end
        end
      end
      if (in_taken) out_expected.push_back(filter_step(s_axis_tdata[SW-1:0]));
      if (in_taken || out_taken) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
          $display("DONE: errors detected");
          $finish;
        end
      end
    end
  end

  // stimulus sequence
  initial begin
    for (int r = 0; r < NUM_REGS; r++) coef_reg[r] = 0;
    coef_reg[REG_COEF_A0]  = longint'(1) <<< COEF_FRAC;
    coef_reg[REG_OUT_GAIN] = longint'(1) <<< GAIN_FRAC;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset settings pass samples straight through
    sample_queue = '{'0, S_MAX, S_MIN, SW'(1), '1, {(SW / 2){2'b01}}, {(SW / 2){2'b10}}};
    wait_idle();

    // writes to spare indexes must change nothing
    for (int i = NUM_REGS; i < (1 << CFG_IDX_W); i++) write_reg(i, $urandom());
    // half weights so that odd samples land exactly on a rounding tie
    write_reg(REG_COEF_A0, 32'h1000_0000);
    write_reg(REG_OUT_GAIN, 32'h0080_0000);
    sample_queue = '{SW'(1), '1, SW'(3), SW'(-3)};
    wait_idle();

    // largest positive and negative weights, saturating both stages
    write_reg(REG_COEF_A0, 32'h7fff_ffff);
    write_reg(REG_COEF_A1, 32'h8000_0000);
    write_reg(REG_COEF_A2, 32'h7fff_ffff);
    write_reg(REG_COEF_B1, 32'h8000_0000);
    write_reg(REG_COEF_B2, 32'h7fff_ffff);
    write_reg(REG_OUT_GAIN, 32'h7fff_ffff);
    sample_queue = '{S_MAX, S_MIN, S_MAX, S_MIN, '0};
    wait_idle();

    for (int r = 0; r < NUM_REGS; r++) write_reg(r, 32'h8000_0000);
    sample_queue = '{S_MIN, S_MAX, SW'(1), S_MIN};

    // random phases, the sender pausing for every result between them
    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      random_config(p % 3);
      if (p == 2 || p == 9) long_hold_req++;
      repeat (PHASE_ITEMS) sample_queue.push_back(random_sample());
    end

    wait_idle();
    repeat (20) @(negedge clk_i);
    if (out_expected.size() != 0) begin
      errors++;
      $display("%0t: %0d results missing, expected %h, actual none", $time,
               out_expected.size(), out_expected[0]);
    end
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
